// ===== design/bssi_pkg.sv =====
// Shared types and constants for the bottom-s sketch insert block.
`default_nettype none
package bssi_pkg;

  localparam int HashW   = 64;
  localparam int IdxW    = 8;
  localparam int SizeW   = 9;
  localparam int BytesW  = 4;
  localparam int StatW   = 3;
  localparam int PosW    = 9;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 9;
  localparam int InDataW  = 72;  // hash_value, read_index
  localparam int OutDataW = 88;  // position, entry_count, entry_value, pad

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SKETCH_SIZE = 2'd0,
    CFG_HASH_BYTES  = 2'd1
  } cfg_idx_e;

  // Item kinds
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_READ_OOR  = 3'd4
  } status_e;

  // Mask keeping the low hash bytes; zero bytes acts as one, above eight as eight
  function automatic logic [HashW-1:0] hash_mask(input logic [BytesW-1:0] nbytes);
    logic [BytesW-1:0] b;
    logic [HashW-1:0]  m;
    b = (nbytes == '0) ? BytesW'(1) : nbytes;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (BytesW'(i) < b) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== design/bssi_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module bssi_ram #(
  parameter int Width = 64,
  parameter int Depth = 256,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/bottom_s_sketch_insert_top.sv =====
// Top level of the bottom-s sketch: sorted hash store in RAM with a scan/shift sequencer.
//
// Channel  | Dir | Signals                                   | Beat
// ---------+-----+-------------------------------------------+------------------------------
// s_axis   | in  | tvalid, tready, tdata[71:0], tuser[0]     | one insert or read item
// m_axis   | out | tvalid, tready, tdata[87:0], tuser[2:0]   | one result per item
// cfg      | in  | cfg_valid_i, cfg_ready_o, index, data     | one register write
//
// A read waits for the registered RAM read (an index beyond the count does not read); an insert
// scans down from the top past each entry above the hash to the entry that stops the scan, then
// moves the entries above its position up one at a time; a duplicate or a reject ends after the scan.
// One item is in work at a time; the next beat is taken the cycle after its result is loaded.
// A stalled result holds the sequencer in its last state. Register writes are taken only while
// idle. Reset empties the sketch (count zero), RAM contents are not cleared.
`default_nettype none
module bottom_s_sketch_insert_top #(
  parameter int MAX_SKETCH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [bssi_pkg::InDataW-1:0]  s_axis_tdata,  // hash_value[63:0], read_index[71:64]
  input  wire logic                          s_axis_tuser,  // operation[0]
  // results
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [bssi_pkg::OutDataW-1:0] m_axis_tdata,  // position[8:0], entry_count[17:9],
                                                            // entry_value[81:18], zero[87:82]
  output logic      [bssi_pkg::StatW-1:0]    m_axis_tuser,  // status[2:0]
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bssi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bssi_pkg::CfgW-1:0]     cfg_data_i
);
  import bssi_pkg::*;

  localparam int CntW = $clog2(MAX_SKETCH + 1);
  localparam int AW   = (MAX_SKETCH > 1) ? $clog2(MAX_SKETCH) : 1;
  localparam int EW   = (CntW > SizeW) ? CntW : SizeW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_PLACE, S_RDWAIT, S_DONE
  } state_e;

  state_e             state_q;
  logic [SizeW-1:0]   size_q;
  logic [BytesW-1:0]  bytes_q;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    pos_q;
  logic [CntW-1:0]    k_q;
  logic [HashW-1:0]   h_q;
  logic [StatW-1:0]   res_stat_q;
  logic [PosW-1:0]    res_pos_q;
  logic [HashW-1:0]   res_val_q;
  logic               m_valid_q;
  logic [StatW-1:0]   m_stat_q;
  logic [PosW-1:0]    m_pos_q;
  logic [PosW-1:0]    m_cnt_q;
  logic [HashW-1:0]   m_val_q;

  // RAM ports
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [HashW-1:0] ram_wdata, ram_rdata;

  // Effective sizes
  logic [CntW-1:0]  eff_size;
  logic [CntW-1:0]  cfg_eff;
  logic [CntW-1:0]  top_idx;
  logic [HashW-1:0] in_hash;
  logic [IdxW-1:0]  in_idx;
  logic             in_take, out_free, rd_in_range;

  function automatic logic [CntW-1:0] clamp_size(input logic [SizeW-1:0] sz);
    return (EW'(sz) > EW'(MAX_SKETCH)) ? CntW'(MAX_SKETCH) : CntW'(sz);
  endfunction

  assign eff_size    = clamp_size(size_q);
  assign cfg_eff     = clamp_size(cfg_data_i[SizeW-1:0]);
  assign top_idx     = (cnt_q < eff_size) ? cnt_q : eff_size - CntW'(1);
  assign in_hash     = s_axis_tdata[HashW-1:0] & hash_mask(bytes_q);
  assign in_idx      = s_axis_tdata[HashW +: IdxW];
  assign rd_in_range = (EW'(in_idx) < EW'(cnt_q)) && (EW'(in_idx) < EW'(MAX_SKETCH));
  assign in_take     = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = (state_q == S_IDLE);

  // RAM address and enable selection
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = AW'(k_q);
    ram_wdata = ram_rdata;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (s_axis_tuser == OP_READ) begin
            ram_re    = rd_in_range;
            ram_raddr = AW'(in_idx);
          end else begin
            ram_re    = (cnt_q != '0);
            ram_raddr = AW'(cnt_q - CntW'(1));
          end
        end
      end
      S_SCAN: begin
        ram_re    = (h_q < ram_rdata) && (pos_q > CntW'(1));
        ram_raddr = AW'(pos_q - CntW'(2));
      end
      S_DECIDE: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(top_idx - CntW'(1));
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = AW'(k_q - CntW'(2));
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_q);
        ram_wdata = h_q;
      end
      default: begin
      end
    endcase
  end

  bssi_ram #(
    .Width(HashW),
    .Depth(MAX_SKETCH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequencer, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      size_q     <= SizeW'(256);
      bytes_q    <= BytesW'(8);
      cnt_q      <= '0;
      pos_q      <= '0;
      k_q        <= '0;
      h_q        <= '0;
      res_stat_q <= ST_INSERTED;
      res_pos_q  <= '0;
      res_val_q  <= '0;
      m_valid_q  <= 1'b0;
      m_stat_q   <= ST_INSERTED;
      m_pos_q    <= '0;
      m_cnt_q    <= '0;
      m_val_q    <= '0;
    end else begin
      // register writes, only while idle
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SKETCH_SIZE: begin
            size_q <= cfg_data_i[SizeW-1:0];
            if (cnt_q > cfg_eff) begin
              cnt_q <= cfg_eff;
            end
          end
          CFG_HASH_BYTES: bytes_q <= cfg_data_i[BytesW-1:0];
          default: begin
          end
        endcase
      end

      // result valid: set on completion, cleared when taken
      if ((state_q == S_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_take) begin
            h_q       <= in_hash;
            pos_q     <= cnt_q;
            res_val_q <= '0;
            if (s_axis_tuser == OP_READ) begin
              res_pos_q  <= PosW'(in_idx);
              res_stat_q <= ST_READ_OOR;
              state_q    <= rd_in_range ? S_RDWAIT : S_DONE;
            end else begin
              state_q <= (cnt_q != '0) ? S_SCAN : S_DECIDE;
            end
          end
        end
        // walk down while the new hash is below the entry
        S_SCAN: begin
          if (h_q < ram_rdata) begin
            pos_q <= pos_q - CntW'(1);
            if (pos_q == CntW'(1)) begin
              state_q <= S_DECIDE;
            end
          end else if (h_q == ram_rdata) begin
            res_stat_q <= ST_DUPLICATE;
            res_pos_q  <= PosW'(pos_q - CntW'(1));
            state_q    <= S_DONE;
          end else begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (pos_q < eff_size) begin
            k_q     <= top_idx;
            state_q <= (top_idx > pos_q) ? S_SHIFT : S_PLACE;
          end else begin
            res_stat_q <= ST_REJECTED;
            res_pos_q  <= PosW'(cnt_q);
            state_q    <= S_DONE;
          end
        end
        // move entry k-1 up to k
        S_SHIFT: begin
          k_q <= k_q - CntW'(1);
          if (k_q - CntW'(1) <= pos_q) begin
            state_q <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (cnt_q < eff_size) begin
            cnt_q <= cnt_q + CntW'(1);
          end
          res_stat_q <= ST_INSERTED;
          res_pos_q  <= PosW'(pos_q);
          state_q    <= S_DONE;
        end
        S_RDWAIT: begin
          res_val_q  <= ram_rdata;
          res_stat_q <= ST_READ_OK;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_stat_q  <= res_stat_q;
            m_pos_q   <= res_pos_q;
            m_cnt_q   <= PosW'(cnt_q);
            m_val_q   <= res_val_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_stat_q;
  assign m_axis_tdata  = {(OutDataW - 2*PosW - HashW)'(0), m_val_q, m_cnt_q, m_pos_q};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(cnt_q) <= EW'(MAX_SKETCH))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("RAM write while idle");

  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (pos_q != '0) && (pos_q <= cnt_q))
    else $error("scan position out of range");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result issued outside completion");

  a_shift_above_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (k_q > pos_q))
    else $error("shift below insert position");
`endif

endmodule
`default_nettype wire
